// ===== design/iiea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iiea_pkg
// Shared sizes, request and status codes, and the command broadcast along the
// cell chain of the indexed insert/erase array.
// ---------------------------------------------------------------------------
package iiea_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 5;
  localparam int REQ_W    = 3;
  localparam int ST_W     = 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [REQ_W-1:0] REQ_READ       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_APPEND     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell; at most one of grow and shrink is set
  typedef struct packed {
    logic              grow;
    logic              shrink;
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

  // request outcome from the controller
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             rd_ok;
    logic [CNT_W-1:0] count_after;
  } req_result_t;

endpackage : iiea_pkg
`default_nettype wire

// ===== design/iiea_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iiea_cell
// One list slot. Holds a word and on a grow or shrink command takes the new
// word, the word of its lower neighbor, or the word of its upper neighbor.
// ---------------------------------------------------------------------------
module iiea_cell
  import iiea_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  cell_idx,
  input  wire cell_cmd_t         cmd,
  input  wire logic [WORD_W-1:0] lower_word,
  input  wire logic [WORD_W-1:0] upper_word,
  output logic      [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    if (cmd.grow) begin
      if (cell_idx == cmd.pos) begin
        word_next = cmd.word;
      end else if (cell_idx > cmd.pos) begin
        word_next = lower_word;
      end
    end else if (cmd.shrink) begin
      if (cell_idx >= cmd.pos) begin
        word_next = upper_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule : iiea_cell
`default_nettype wire

// ===== design/iiea_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iiea_ctrl
// Request decode: range and full checks, the element count register, and the
// grow/shrink command for the cell chain.
// ---------------------------------------------------------------------------
module iiea_ctrl
  import iiea_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [WORD_W-1:0] data_word,
  output cell_cmd_t              cmd,
  output req_result_t            res
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] pos_c;
  logic             full;
  logic             grow;
  logic             shrink;
  logic [ST_W-1:0]  status;
  logic             rd_ok;
  logic [IDX_W-1:0] tgt;

  assign pos_c = CNT_W'(position);
  assign full  = (count >= CNT_W'(CAPACITY));

  always_comb begin
    grow   = 1'b0;
    shrink = 1'b0;
    status = ST_OK;
    rd_ok  = 1'b0;
    tgt    = position[IDX_W-1:0];
    unique case (req_type)
      REQ_READ: begin
        if (pos_c < count) begin
          rd_ok = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      REQ_INSERT: begin
        if (pos_c > count) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          grow = 1'b1;
        end
      end
      REQ_ERASE: begin
        if (pos_c >= count) begin
          status = ST_RANGE;
        end else begin
          shrink = 1'b1;
        end
      end
      REQ_APPEND: begin
        tgt = count[IDX_W-1:0];
        if (full) begin
          status = ST_FULL;
        end else begin
          grow = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        tgt = '0;
        if (full) begin
          status = ST_FULL;
        end else begin
          grow = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (grow) begin
      count_next = count + CNT_W'(1);
    end else if (shrink) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  assign cmd.grow        = fire & grow;
  assign cmd.shrink      = fire & shrink;
  assign cmd.pos         = tgt;
  assign cmd.word        = data_word;
  assign res.status      = status;
  assign res.rd_ok       = rd_ok;
  assign res.count_after = count_next;

endmodule : iiea_ctrl
`default_nettype wire

// ===== design/indexed_insert_erase_array.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_insert_erase_array
// Fixed-capacity ordered list of 64-bit words held in a chain of cells.
// Supports read, insert, erase, push back and push front by position.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  request | in_valid / in_ready  | req_type, position, data_word
//  result  | out_valid / out_ready| read_word, element_count, status
//
//  One request per cycle unless the output stalls: each cell shifts or loads
//  in the accept cycle and the registered result appears the cycle after it.
//  A new request is taken while the result register is empty or being drained.
//  Reset clears the count and the result valid; stored words are left as is.
//  An output stall holds in_ready low only while the held result is not taken.
// ---------------------------------------------------------------------------
module indexed_insert_erase_array
  import iiea_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [WORD_W-1:0] data_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WORD_W-1:0] read_word,
  output logic      [CNT_W-1:0]  element_count,
  output logic      [ST_W-1:0]   status
);

  logic              fire;
  cell_cmd_t         cmd;
  req_result_t       res;
  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] sel_word;

  assign in_ready = ~out_valid | out_ready;
  assign fire     = in_valid & in_ready;

  iiea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req_type  (req_type),
    .position  (position),
    .data_word (data_word),
    .cmd       (cmd),
    .res       (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = cell_word[i-1];
    end
    // top cell has no upper neighbor; the slot it vacates is never read
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = cell_word[i+1];
    end
    iiea_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .cmd        (cmd),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word       (cell_word[i])
    );
  end

  assign sel_word = res.rd_ok ? cell_word[position[IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_word     <= sel_word;
      element_count <= res.count_after;
      status        <= res.status;
    end
  end

endmodule : indexed_insert_erase_array
`default_nettype wire

// ===== test/indexed_insert_erase_array_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_insert_erase_array_tb
// Drives read, insert, erase and push requests into the ordered word list and
// checks every result against a shadow copy of the list kept in the bench.
// A short table of corner cases runs first, then random requests that swing
// the list between empty and full under different amounts of idling.
// ---------------------------------------------------------------------------
module indexed_insert_erase_array_tb;
  import iiea_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
  localparam int N_DIRECTED = 22;
  localparam int PHASE_REQS = 432;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]  element_count;
    logic [ST_W-1:0]   status;
  } list_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              fixed;
    list_result_t      want;
  } list_row_t;

  typedef enum {TREND_FILL, TREND_DRAIN, TREND_CHURN} list_trend_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = REQ_READ;
  logic [POS_W-1:0]  position = '0;
  logic [WORD_W-1:0] data_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] read_word;
  logic [CNT_W-1:0]  element_count;
  logic [ST_W-1:0]   status;

  // shadow copy of the list
  logic [WORD_W-1:0] shadow_words [CAPACITY];
  int unsigned       shadow_len = 0;

  list_result_t pending_results [$];
  int mismatches = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // corner cases; fixed = 1 rows carry their expected result
  list_row_t corner_rows [N_DIRECTED] = '{
    '{REQ_READ,       5'd0,  64'd0, 1'b1, '{64'd0, 5'd0, ST_RANGE}},
    '{REQ_ERASE,      5'd0,  64'd0, 1'b1, '{64'd0, 5'd0, ST_RANGE}},
    '{REQ_INSERT,     5'd1,  ONES,  1'b1, '{64'd0, 5'd0, ST_RANGE}},
    '{REQ_INSERT,     5'd0,  ONES,  1'b1, '{64'd0, 5'd1, ST_OK}},
    '{REQ_READ,       5'd0,  64'd0, 1'b1, '{ONES,  5'd1, ST_OK}},
    '{REQ_APPEND,     5'd31, 64'd0, 1'b1, '{64'd0, 5'd2, ST_OK}},
    '{REQ_PUSH_FRONT, 5'd31, 64'h5555_5555_5555_5555, 1'b1, '{64'd0, 5'd3, ST_OK}},
    '{REQ_SPARE_5,    5'd0,  ONES,  1'b1, '{64'd0, 5'd3, ST_OK}},
    '{REQ_SPARE_6,    5'd1,  ONES,  1'b1, '{64'd0, 5'd3, ST_OK}},
    '{REQ_SPARE_7,    5'd31, ONES,  1'b1, '{64'd0, 5'd3, ST_OK}},
    '{REQ_READ,       5'd31, 64'd0, 1'b1, '{64'd0, 5'd3, ST_RANGE}},
    '{REQ_READ,       5'd3,  64'd0, 1'b1, '{64'd0, 5'd3, ST_RANGE}},
    '{REQ_ERASE,      5'd3,  64'd0, 1'b1, '{64'd0, 5'd3, ST_RANGE}},
    '{REQ_INSERT,     5'd4,  ONES,  1'b1, '{64'd0, 5'd3, ST_RANGE}},
    '{REQ_INSERT,     5'd3,  64'haaaa_aaaa_aaaa_aaaa, 1'b1, '{64'd0, 5'd4, ST_OK}},
    '{REQ_INSERT,     5'd1,  64'h0123_4567_89ab_cdef, 1'b0, '0},
    '{REQ_READ,       5'd2,  64'd0, 1'b0, '0},
    '{REQ_ERASE,      5'd0,  64'd0, 1'b0, '0},
    '{REQ_READ,       5'd0,  64'd0, 1'b0, '0},
    '{REQ_ERASE,      5'd3,  64'd0, 1'b0, '0},
    '{REQ_READ,       5'd2,  ONES,  1'b0, '0},
    '{REQ_READ,       5'd16, ONES,  1'b0, '0}
  };

  indexed_insert_erase_array u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .position      (position),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_word     (read_word),
    .element_count (element_count),
    .status        (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // open a slot at pos and store the word there, later words move up
  function automatic void open_slot(int unsigned pos, logic [WORD_W-1:0] word);
    for (int unsigned i = shadow_len; i > pos; i--) begin
      shadow_words[i] = shadow_words[i - 1];
    end
    shadow_words[pos] = word;
    shadow_len++;
  endfunction

  function automatic list_result_t apply_request(logic [REQ_W-1:0] rq, logic [POS_W-1:0] ps,
                                                 logic [WORD_W-1:0] wd);
    list_result_t r;
    r = '0;
    r.status = ST_OK;
    case (rq)
      REQ_READ: begin
        if (ps < shadow_len) r.read_word = shadow_words[ps];
        else r.status = ST_RANGE;
      end
      REQ_INSERT: begin
        if (ps > shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_slot(ps, wd);
      end
      REQ_ERASE: begin
        if (ps >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = ps; i + 1 < shadow_len; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_len--;
        end
      end
      REQ_APPEND: begin
        if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_slot(shadow_len, wd);
      end
      REQ_PUSH_FRONT: begin
        if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_slot(0, wd);
      end
      default: ;
    endcase
    r.element_count = shadow_len[CNT_W-1:0];
    return r;
  endfunction

  // holds the request until accepted, then records what it should return
  task automatic issue_request(logic [REQ_W-1:0] rq, logic [POS_W-1:0] ps,
                               logic [WORD_W-1:0] wd, logic fixed, list_result_t want);
    list_result_t predicted;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    position  <= ps;
    data_word <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(rq, ps, wd);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h count %0d status %0d",
                 $time, read_word, element_count, status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_word !== want.read_word) begin
          $display("%0t: read_word expected %h got %h", $time, want.read_word, read_word);
          mismatches++;
        end
        if (element_count !== want.element_count) begin
          $display("%0t: element_count expected %0d got %0d",
                   $time, want.element_count, element_count);
          mismatches++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          mismatches++;
        end
      end
    end
  end

  // ends the run if the block stops taking or giving anything
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    list_trend_t       trend;
    int                grow_pct;
    int                pick;
    logic [REQ_W-1:0]  rq;
    logic [POS_W-1:0]  ps;
    logic [WORD_W-1:0] wd;

    trend = TREND_FILL;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_request(corner_rows[i].req, corner_rows[i].pos, corner_rows[i].word,
                    corner_rows[i].fixed, corner_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        // runs of requests that lean toward filling or emptying the list
        if (n % 32 == 0) trend = list_trend_t'($urandom_range(2));
        grow_pct = (trend == TREND_FILL) ? 75 : (trend == TREND_DRAIN) ? 15 : 45;
        pick = $urandom_range(99);
        if (pick < 4) begin
          rq = REQ_SPARE_5 + REQ_W'($urandom_range(2));
        end else if (pick < 4 + grow_pct) begin
          case ($urandom_range(2))
            0: rq = REQ_INSERT;
            1: rq = REQ_APPEND;
            default: rq = REQ_PUSH_FRONT;
          endcase
        end else begin
          rq = $urandom_range(1) ? REQ_READ : REQ_ERASE;
        end

        pick = $urandom_range(99);
        if (pick < 75) ps = POS_W'($urandom_range(shadow_len));
        else if (pick < 85) ps = POS_W'(shadow_len);
        else ps = POS_W'($urandom_range(31));

        pick = $urandom_range(99);
        if (pick < 10) wd = ONES;
        else if (pick < 15) wd = '0;
        else wd = {$urandom, $urandom};

        issue_request(rq, ps, wd, 1'b0, '0);
      end
      // sender holds off until the block has handed back everything
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
